/* rtl/dasp_pkg.sv */
// Shared types and constants for the distance attenuated stereo pan block.
// Used by the top level, the square root and divider pipelines and the output buffer.
`default_nettype none

package dasp_pkg;

    // Square root pipeline: one root bit per stage.
    localparam int SQ_RAD_W  = 62;
    localparam int SQ_ROOT_W = 31;
    localparam int SQ_STAGES = SQ_ROOT_W;

    // Divider pipeline: one quotient bit per stage.
    localparam int DV_NUM_W  = 46;
    localparam int DV_DEN_W  = 31;
    localparam int DV_Q_W    = 16;
    localparam int DV_STAGES = DV_Q_W;

    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORWARD_X = 3'd0,
        CFG_FORWARD_Y = 3'd1,
        CFG_FORWARD_Z = 3'd2,
        CFG_UP_X      = 3'd3,
        CFG_UP_Y      = 3'd4,
        CFG_UP_Z      = 3'd5,
        CFG_ROLLOFF   = 3'd6,
        CFG_MAX_RANGE = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic signed [23:0] src_x;
        logic signed [23:0] src_y;
        logic signed [23:0] src_z;
        logic signed [23:0] lis_x;
        logic signed [23:0] lis_y;
        logic signed [23:0] lis_z;
        logic [15:0]        volume;
        logic signed [15:0] sample;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } out_item_t;

    // Data that rides along the square root pipeline.
    typedef struct packed {
        logic signed [15:0] sample;
        logic [15:0]        volume;
        logic [29:0]        ax;
        logic               neg;
    } sq_side_t;

    // Data that rides along the divider pipeline.
    typedef struct packed {
        logic signed [15:0] sample;
        logic               silent;
        logic               hzero;
        logic               neg;
    } dv_side_t;

endpackage

`default_nettype wire

/* rtl/dasp_isqrt.sv */
// Two-lane pipelined integer square root, one root bit resolved per stage.
// Depends on dasp_pkg for widths and the sideband type.
`default_nettype none

module dasp_isqrt
    import dasp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [SQ_RAD_W-1:0]  rad0,
    input  wire logic [SQ_RAD_W-1:0]  rad1,
    input  wire sq_side_t             in_side,
    output logic                      out_valid,
    output logic [SQ_ROOT_W-1:0]      root0,
    output logic [SQ_ROOT_W-1:0]      root1,
    output sq_side_t                  out_side
);

    logic [SQ_RAD_W-1:0]  rem_reg  [SQ_STAGES][2];
    logic [SQ_ROOT_W-1:0] root_reg [SQ_STAGES][2];
    sq_side_t             side_reg [SQ_STAGES];
    logic                 vld_reg  [SQ_STAGES];

    logic [SQ_RAD_W-1:0]  rem_src   [SQ_STAGES][2];
    logic [SQ_ROOT_W-1:0] root_src  [SQ_STAGES][2];
    logic [SQ_RAD_W-1:0]  rem_next  [SQ_STAGES][2];
    logic [SQ_ROOT_W-1:0] root_next [SQ_STAGES][2];

    // Setting root bit k costs (root << (k+1)) + 4^k out of the remainder.
    function automatic logic [SQ_RAD_W-1:0] trial(input logic [SQ_ROOT_W-1:0] root,
                                                  input int k);
        return (SQ_RAD_W'(root) << (k + 1)) | (SQ_RAD_W'(1) << (2 * k));
    endfunction

    always_comb
    begin
        for (int j = 0; j < SQ_STAGES; j++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                if (j == 0)
                begin
                    rem_src[j][l]  = (l == 0) ? rad0 : rad1;
                    root_src[j][l] = '0;
                end
                else
                begin
                    rem_src[j][l]  = rem_reg[j-1][l];
                    root_src[j][l] = root_reg[j-1][l];
                end
                if (rem_src[j][l] >= trial(root_src[j][l], SQ_STAGES - 1 - j))
                begin
                    rem_next[j][l]  = rem_src[j][l] - trial(root_src[j][l], SQ_STAGES - 1 - j);
                    root_next[j][l] = root_src[j][l] | (SQ_ROOT_W'(1) << (SQ_STAGES - 1 - j));
                end
                else
                begin
                    rem_next[j][l]  = rem_src[j][l];
                    root_next[j][l] = root_src[j][l];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < SQ_STAGES; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int j = 0; j < SQ_STAGES; j++)
            begin
                vld_reg[j] <= (j == 0) ? in_valid : vld_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < SQ_STAGES; j++)
            begin
                rem_reg[j][0]  <= rem_next[j][0];
                rem_reg[j][1]  <= rem_next[j][1];
                root_reg[j][0] <= root_next[j][0];
                root_reg[j][1] <= root_next[j][1];
                side_reg[j]    <= (j == 0) ? in_side : side_reg[j-1];
            end
        end
    end

    assign out_valid = vld_reg[SQ_STAGES-1];
    assign root0     = root_reg[SQ_STAGES-1][0];
    assign root1     = root_reg[SQ_STAGES-1][1];
    assign out_side  = side_reg[SQ_STAGES-1];

endmodule

`default_nettype wire

/* rtl/dasp_div.sv */
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Depends on dasp_pkg; the quotient must fit in DV_Q_W bits.
`default_nettype none

module dasp_div
    import dasp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [DV_NUM_W-1:0]  num0,
    input  wire logic [DV_DEN_W-1:0]  den0,
    input  wire logic [DV_NUM_W-1:0]  num1,
    input  wire logic [DV_DEN_W-1:0]  den1,
    input  wire dv_side_t             in_side,
    output logic                      out_valid,
    output logic [DV_Q_W-1:0]         quo0,
    output logic [DV_Q_W-1:0]         quo1,
    output dv_side_t                  out_side
);

    logic [DV_NUM_W-1:0] rem_reg [DV_STAGES][2];
    logic [DV_DEN_W-1:0] den_reg [DV_STAGES][2];
    logic [DV_Q_W-1:0]   quo_reg [DV_STAGES][2];
    dv_side_t            side_reg [DV_STAGES];
    logic                vld_reg  [DV_STAGES];

    logic [DV_NUM_W-1:0] rem_src  [DV_STAGES][2];
    logic [DV_DEN_W-1:0] den_src  [DV_STAGES][2];
    logic [DV_Q_W-1:0]   quo_src  [DV_STAGES][2];
    logic [DV_NUM_W-1:0] rem_next [DV_STAGES][2];
    logic [DV_Q_W-1:0]   quo_next [DV_STAGES][2];

    always_comb
    begin
        for (int j = 0; j < DV_STAGES; j++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                if (j == 0)
                begin
                    rem_src[j][l] = (l == 0) ? num0 : num1;
                    den_src[j][l] = (l == 0) ? den0 : den1;
                    quo_src[j][l] = '0;
                end
                else
                begin
                    rem_src[j][l] = rem_reg[j-1][l];
                    den_src[j][l] = den_reg[j-1][l];
                    quo_src[j][l] = quo_reg[j-1][l];
                end
                if (rem_src[j][l] >= (DV_NUM_W'(den_src[j][l]) << (DV_STAGES - 1 - j)))
                begin
                    rem_next[j][l] = rem_src[j][l]
                                     - (DV_NUM_W'(den_src[j][l]) << (DV_STAGES - 1 - j));
                    quo_next[j][l] = quo_src[j][l] | (DV_Q_W'(1) << (DV_STAGES - 1 - j));
                end
                else
                begin
                    rem_next[j][l] = rem_src[j][l];
                    quo_next[j][l] = quo_src[j][l];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < DV_STAGES; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int j = 0; j < DV_STAGES; j++)
            begin
                vld_reg[j] <= (j == 0) ? in_valid : vld_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < DV_STAGES; j++)
            begin
                rem_reg[j][0] <= rem_next[j][0];
                rem_reg[j][1] <= rem_next[j][1];
                den_reg[j][0] <= den_src[j][0];
                den_reg[j][1] <= den_src[j][1];
                quo_reg[j][0] <= quo_next[j][0];
                quo_reg[j][1] <= quo_next[j][1];
                side_reg[j]   <= (j == 0) ? in_side : side_reg[j-1];
            end
        end
    end

    assign out_valid = vld_reg[DV_STAGES-1];
    assign quo0      = quo_reg[DV_STAGES-1][0];
    assign quo1      = quo_reg[DV_STAGES-1][1];
    assign out_side  = side_reg[DV_STAGES-1];

endmodule

`default_nettype wire

/* rtl/dasp_outbuf.sv */
// Output register with a one-entry skid stage for the result channel.
// Depends on dasp_pkg for the result type; drives the pipeline advance enable.
`default_nettype none

module dasp_outbuf
    import dasp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      pipe_valid,
    input  wire out_item_t pipe_data,
    output logic           advance,
    output logic           result_valid,
    input  wire logic      result_stall,
    output out_item_t      result
);

    logic      out_vld_reg;
    logic      skid_vld_reg;
    out_item_t out_reg;
    out_item_t skid_reg;
    logic      take;

    assign take    = out_vld_reg && !result_stall;
    // The pipeline moves whenever the skid entry is free.
    assign advance = !skid_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (take)
            begin
                skid_vld_reg <= 1'b0;
            end
        end
        else if (pipe_valid)
        begin
            if (out_vld_reg && !take)
            begin
                skid_vld_reg <= 1'b1;
            end
            else
            begin
                out_vld_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (pipe_valid)
        begin
            if (out_vld_reg && !take)
            begin
                skid_reg <= pipe_data;
            end
            else
            begin
                out_reg <= pipe_data;
            end
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

/* rtl/distance_attenuated_stereo_pan.sv */
// Top level of the distance attenuated stereo pan block.
// Depends on dasp_pkg, dasp_isqrt, dasp_div and dasp_outbuf.
`default_nettype none

// Takes one source item per clock while not stalled and returns one stereo result per
// item, in order. Each result passes the front end stages, the 31-stage square root
// pipeline (one root bit per stage), the attenuation stages, the 16-stage divider
// pipeline and the output multiplier stages before it leaves the output register.
// The whole pipeline advances together; input stalls while the one-entry skid stage
// behind the output register is full, which only happens after a result has been held
// by a stalled result side, and it clears on the cycle after the waiting result is taken.
// Configuration registers take effect for items accepted on the cycle after the write.
module distance_attenuated_stereo_pan
    import dasp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire in_item_t              item,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output out_item_t                  result
);

    // Configuration
    logic signed [15:0] fwd_x_reg, fwd_y_reg, fwd_z_reg;
    logic signed [15:0] up_x_reg, up_y_reg, up_z_reg;
    logic [15:0]        rolloff_reg;
    logic [23:0]        max_range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_x_reg     <= 16'sd0;
            fwd_y_reg     <= 16'sd0;
            fwd_z_reg     <= 16'sd16384;
            up_x_reg      <= 16'sd0;
            up_y_reg      <= 16'sd16384;
            up_z_reg      <= 16'sd0;
            rolloff_reg   <= 16'd256;
            max_range_reg <= 24'd16777215;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FORWARD_X: fwd_x_reg     <= cfg_data[15:0];
                CFG_FORWARD_Y: fwd_y_reg     <= cfg_data[15:0];
                CFG_FORWARD_Z: fwd_z_reg     <= cfg_data[15:0];
                CFG_UP_X:      up_x_reg      <= cfg_data[15:0];
                CFG_UP_Y:      up_y_reg      <= cfg_data[15:0];
                CFG_UP_Z:      up_z_reg      <= cfg_data[15:0];
                CFG_ROLLOFF:   rolloff_reg   <= cfg_data[15:0];
                CFG_MAX_RANGE: max_range_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Listener right vector = forward x up, refreshed every cycle from the registers.
    logic signed [31:0] rp_reg [6];
    logic signed [32:0] rdiff_x, rdiff_y, rdiff_z;
    logic signed [18:0] rx_reg, ry_reg, rz_reg;

    assign rdiff_x = 33'(rp_reg[0]) - 33'(rp_reg[1]);
    assign rdiff_y = 33'(rp_reg[2]) - 33'(rp_reg[3]);
    assign rdiff_z = 33'(rp_reg[4]) - 33'(rp_reg[5]);

    always_ff @(posedge clk)
    begin
        rp_reg[0] <= fwd_y_reg * up_z_reg;
        rp_reg[1] <= fwd_z_reg * up_y_reg;
        rp_reg[2] <= fwd_z_reg * up_x_reg;
        rp_reg[3] <= fwd_x_reg * up_z_reg;
        rp_reg[4] <= fwd_x_reg * up_y_reg;
        rp_reg[5] <= fwd_y_reg * up_x_reg;
        rx_reg    <= 19'(rdiff_x >>> 14);
        ry_reg    <= 19'(rdiff_y >>> 14);
        rz_reg    <= 19'(rdiff_z >>> 14);
    end

    logic en;
    assign item_stall = !en;

    // Front end pipeline registers
    logic               s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    logic               s6_vld_reg, s7_vld_reg, s8_vld_reg, s9_vld_reg, s10_vld_reg;
    in_item_t           s1_item_reg;
    logic signed [24:0] s2_dx_reg, s2_dy_reg, s2_dz_reg;
    logic signed [24:0] s3_dx_reg, s3_dy_reg, s3_dz_reg;
    logic [49:0]        s3_qx_reg, s3_qy_reg, s3_qz_reg;
    logic [49:0]        s4_sumsq_reg, s5_sumsq_reg, s6_sumsq_reg, s7_sumsq_reg;
    logic [49:0]        s8_sumsq_reg, s9_sumsq_reg, s10_sumsq_reg;
    logic signed [43:0] s4_plx_reg [3];
    logic signed [40:0] s4_plz_reg [3];
    logic signed [45:0] s5_lx_reg, s5_lz_reg;
    logic [45:0]        s6_ax_reg, s6_az_reg, s7_ax_reg, s7_az_reg;
    logic [4:0]         s7_sh_reg;
    logic [29:0]        s8_ax_reg, s8_az_reg, s9_ax_reg, s10_ax_reg;
    logic [59:0]        s9_qx_reg, s9_qz_reg;
    logic [60:0]        s10_hsum_reg;
    logic               s6_neg_reg, s7_neg_reg, s8_neg_reg, s9_neg_reg, s10_neg_reg;
    logic [15:0]        s2_vol_reg, s3_vol_reg, s4_vol_reg, s5_vol_reg, s6_vol_reg;
    logic [15:0]        s7_vol_reg, s8_vol_reg, s9_vol_reg, s10_vol_reg;
    logic signed [15:0] s2_smp_reg, s3_smp_reg, s4_smp_reg, s5_smp_reg, s6_smp_reg;
    logic signed [15:0] s7_smp_reg, s8_smp_reg, s9_smp_reg, s10_smp_reg;

    logic [45:0] s6_max;
    logic [4:0]  s7_sh_next;

    assign s6_max = (s6_ax_reg > s6_az_reg) ? s6_ax_reg : s6_az_reg;

    // Smallest right shift that brings the larger magnitude below 2^30.
    always_comb
    begin
        s7_sh_next = '0;
        for (int i = 30; i < 46; i++)
        begin
            if (s6_max[i])
            begin
                s7_sh_next = 5'(i - 29);
            end
        end
    end

    // Square root results and the attenuation stages
    logic                 sq_vld;
    logic [SQ_ROOT_W-1:0] sq_dist, sq_h;
    sq_side_t             sq_side, s10_side;

    logic               r1_vld_reg, r2_vld_reg, r3_vld_reg;
    logic               r1_over_reg, r2_over_reg;
    logic [24:0]        r1_dm_reg;
    logic [26:0]        r1_v2k_reg, r2_v2k_reg;
    logic [40:0]        r2_denp_reg;
    logic [DV_DEN_W-1:0] r3_den_reg;
    logic               r3_silent_reg, r3_hzero_reg;
    logic [SQ_ROOT_W-1:0] r1_h_reg, r2_h_reg, r3_h_reg;
    sq_side_t           r1_side_reg, r2_side_reg, r3_side_reg;

    logic [24:0] r1_dist;
    logic [41:0] r3_den;

    assign r1_dist = (sq_dist[24:0] < 25'd256) ? 25'd256 : sq_dist[24:0];
    assign r3_den  = 42'd65536 + 42'(r2_denp_reg);

    // Divider results and output stages
    logic              dv_vld;
    logic [DV_Q_W-1:0] dv_gain, dv_pan;
    dv_side_t          dv_side, r3_dv_side;

    logic               f1_vld_reg, f2_vld_reg, f3_vld_reg;
    logic [15:0]        f1_gain_reg;
    logic signed [15:0] f1_smp_reg;
    logic signed [17:0] f1_pa_reg, f1_pb_reg, f2_pa_reg, f2_pb_reg;
    logic signed [32:0] f2_sg_reg;
    logic signed [50:0] f3_pl_reg, f3_pr_reg;

    logic [15:0]        f1_pm;
    logic signed [17:0] f1_pan;

    assign f1_pm  = dv_side.hzero ? 16'd0 : ((dv_pan > 16'd32768) ? 16'd32768 : dv_pan);
    assign f1_pan = dv_side.neg ? -18'(f1_pm) : 18'(f1_pm);

    function automatic logic signed [15:0] round_sat(input logic signed [50:0] p);
        logic signed [50:0] biased;
        logic signed [19:0] v;
        biased = p + 51'sd1073741824;
        v = 20'(biased >>> 31);
        if (v > 20'sd32767)
        begin
            return 16'sh7fff;
        end
        else if (v < -20'sd32768)
        begin
            return 16'sh8000;
        end
        else
        begin
            return 16'(v);
        end
    endfunction

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            r1_vld_reg  <= 1'b0;
            r2_vld_reg  <= 1'b0;
            r3_vld_reg  <= 1'b0;
            f1_vld_reg  <= 1'b0;
            f2_vld_reg  <= 1'b0;
            f3_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= item_valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= s7_vld_reg;
            s9_vld_reg  <= s8_vld_reg;
            s10_vld_reg <= s9_vld_reg;
            r1_vld_reg  <= sq_vld;
            r2_vld_reg  <= r1_vld_reg;
            r3_vld_reg  <= r2_vld_reg;
            f1_vld_reg  <= dv_vld;
            f2_vld_reg  <= f1_vld_reg;
            f3_vld_reg  <= f2_vld_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg <= item;

            s2_dx_reg  <= 25'(s1_item_reg.src_x) - 25'(s1_item_reg.lis_x);
            s2_dy_reg  <= 25'(s1_item_reg.src_y) - 25'(s1_item_reg.lis_y);
            s2_dz_reg  <= 25'(s1_item_reg.src_z) - 25'(s1_item_reg.lis_z);
            s2_vol_reg <= s1_item_reg.volume;
            s2_smp_reg <= s1_item_reg.sample;

            s3_qx_reg  <= s2_dx_reg * s2_dx_reg;
            s3_qy_reg  <= s2_dy_reg * s2_dy_reg;
            s3_qz_reg  <= s2_dz_reg * s2_dz_reg;
            s3_dx_reg  <= s2_dx_reg;
            s3_dy_reg  <= s2_dy_reg;
            s3_dz_reg  <= s2_dz_reg;
            s3_vol_reg <= s2_vol_reg;
            s3_smp_reg <= s2_smp_reg;

            s4_sumsq_reg  <= s3_qx_reg + s3_qy_reg + s3_qz_reg;
            s4_plx_reg[0] <= s3_dx_reg * rx_reg;
            s4_plx_reg[1] <= s3_dy_reg * ry_reg;
            s4_plx_reg[2] <= s3_dz_reg * rz_reg;
            s4_plz_reg[0] <= s3_dx_reg * fwd_x_reg;
            s4_plz_reg[1] <= s3_dy_reg * fwd_y_reg;
            s4_plz_reg[2] <= s3_dz_reg * fwd_z_reg;
            s4_vol_reg    <= s3_vol_reg;
            s4_smp_reg    <= s3_smp_reg;

            s5_lx_reg    <= 46'(s4_plx_reg[0]) + 46'(s4_plx_reg[1]) + 46'(s4_plx_reg[2]);
            s5_lz_reg    <= 46'(s4_plz_reg[0]) + 46'(s4_plz_reg[1]) + 46'(s4_plz_reg[2]);
            s5_sumsq_reg <= s4_sumsq_reg;
            s5_vol_reg   <= s4_vol_reg;
            s5_smp_reg   <= s4_smp_reg;

            s6_ax_reg    <= s5_lx_reg[45] ? 46'(-s5_lx_reg) : 46'(s5_lx_reg);
            s6_az_reg    <= s5_lz_reg[45] ? 46'(-s5_lz_reg) : 46'(s5_lz_reg);
            s6_neg_reg   <= s5_lx_reg[45];
            s6_sumsq_reg <= s5_sumsq_reg;
            s6_vol_reg   <= s5_vol_reg;
            s6_smp_reg   <= s5_smp_reg;

            s7_sh_reg    <= s7_sh_next;
            s7_ax_reg    <= s6_ax_reg;
            s7_az_reg    <= s6_az_reg;
            s7_neg_reg   <= s6_neg_reg;
            s7_sumsq_reg <= s6_sumsq_reg;
            s7_vol_reg   <= s6_vol_reg;
            s7_smp_reg   <= s6_smp_reg;

            s8_ax_reg    <= 30'(s7_ax_reg >> s7_sh_reg);
            s8_az_reg    <= 30'(s7_az_reg >> s7_sh_reg);
            s8_neg_reg   <= s7_neg_reg;
            s8_sumsq_reg <= s7_sumsq_reg;
            s8_vol_reg   <= s7_vol_reg;
            s8_smp_reg   <= s7_smp_reg;

            s9_qx_reg    <= s8_ax_reg * s8_ax_reg;
            s9_qz_reg    <= s8_az_reg * s8_az_reg;
            s9_ax_reg    <= s8_ax_reg;
            s9_neg_reg   <= s8_neg_reg;
            s9_sumsq_reg <= s8_sumsq_reg;
            s9_vol_reg   <= s8_vol_reg;
            s9_smp_reg   <= s8_smp_reg;

            s10_hsum_reg  <= 61'(s9_qx_reg) + 61'(s9_qz_reg);
            s10_ax_reg    <= s9_ax_reg;
            s10_neg_reg   <= s9_neg_reg;
            s10_sumsq_reg <= s9_sumsq_reg;
            s10_vol_reg   <= s9_vol_reg;
            s10_smp_reg   <= s9_smp_reg;

            r1_over_reg <= r1_dist > {1'b0, max_range_reg};
            r1_dm_reg   <= r1_dist - 25'd256;
            r1_v2k_reg  <= 27'(sq_side.volume) * 27'd2000;
            r1_h_reg    <= sq_h;
            r1_side_reg <= sq_side;

            r2_denp_reg <= 41'(rolloff_reg) * 41'(r1_dm_reg);
            r2_over_reg <= r1_over_reg;
            r2_v2k_reg  <= r1_v2k_reg;
            r2_h_reg    <= r1_h_reg;
            r2_side_reg <= r1_side_reg;

            // Gain at or below one two-thousandth, or a distance beyond the maximum range, silences the item.
            r3_silent_reg <= r2_over_reg || (42'(r2_v2k_reg) <= r3_den);
            r3_den_reg    <= r3_den[DV_DEN_W-1:0];
            r3_hzero_reg  <= (r2_h_reg == '0);
            r3_h_reg      <= r2_h_reg;
            r3_side_reg   <= r2_side_reg;

            f1_gain_reg <= dv_side.silent ? 16'd0 : dv_gain;
            f1_pa_reg   <= 18'sd32768 - f1_pan;
            f1_pb_reg   <= 18'sd32768 + f1_pan;
            f1_smp_reg  <= dv_side.sample;

            f2_sg_reg <= f1_smp_reg * $signed({1'b0, f1_gain_reg});
            f2_pa_reg <= f1_pa_reg;
            f2_pb_reg <= f1_pb_reg;

            f3_pl_reg <= f2_sg_reg * f2_pa_reg;
            f3_pr_reg <= f2_sg_reg * f2_pb_reg;
        end
    end

    assign s10_side.sample = s10_smp_reg;
    assign s10_side.volume = s10_vol_reg;
    assign s10_side.ax     = s10_ax_reg;
    assign s10_side.neg    = s10_neg_reg;

    dasp_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s10_vld_reg),
        .rad0      (SQ_RAD_W'(s10_sumsq_reg)),
        .rad1      (SQ_RAD_W'(s10_hsum_reg)),
        .in_side   (s10_side),
        .out_valid (sq_vld),
        .root0     (sq_dist),
        .root1     (sq_h),
        .out_side  (sq_side)
    );

    assign r3_dv_side.sample = r3_side_reg.sample;
    assign r3_dv_side.silent = r3_silent_reg;
    assign r3_dv_side.hzero  = r3_hzero_reg;
    assign r3_dv_side.neg    = r3_side_reg.neg;

    dasp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r3_vld_reg),
        .num0      (DV_NUM_W'({r3_side_reg.volume, 16'd0})),
        .den0      (r3_den_reg),
        .num1      (DV_NUM_W'({r3_side_reg.ax, 15'd0})),
        .den1      (r3_h_reg),
        .in_side   (r3_dv_side),
        .out_valid (dv_vld),
        .quo0      (dv_gain),
        .quo1      (dv_pan),
        .out_side  (dv_side)
    );

    out_item_t f3_result;

    assign f3_result.left  = round_sat(f3_pl_reg);
    assign f3_result.right = round_sat(f3_pr_reg);

    dasp_outbuf u_outbuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .pipe_valid   (f3_vld_reg),
        .pipe_data    (f3_result),
        .advance      (en),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

/* rtl/dasp_checker.sv */
// Port-level checker for the distance attenuated stereo pan block, bound to the top.
// Depends on dasp_pkg for the result type.
`default_nettype none

module dasp_checker
    import dasp_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      item_stall,
    input wire logic      result_valid,
    input wire logic      result_stall,
    input wire out_item_t result
);

    // A result that is held back keeps its value.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed or was dropped");

    // Input back-pressure only ever comes from a stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(item_stall) |-> $past(result_valid && result_stall))
        else $error("input stalled without a stalled result");

    // While the input is held off, a result is waiting at the output.
    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("input stalled with no result pending");

    // Once the waiting result is taken, the input is released on the next cycle.
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall && !result_stall |=> !item_stall)
        else $error("input stall not released after result taken");

endmodule

bind distance_attenuated_stereo_pan dasp_checker u_dasp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
